// ===== rtl/cfr_pkg.sv =====
// Package for the chunk frame receiver.
// Holds the item and result types, role and error codes, and the hex digit decoder.
// No dependencies.
`default_nettype none

package cfr_pkg;

  localparam int ByteW = 8;

  localparam logic [ByteW-1:0] ChType_Ext  = 8'h78;  // 'x'
  localparam logic [ByteW-1:0] ChType_Data = 8'h64;  // 'd'
  localparam logic [ByteW-1:0] ChSemi      = 8'h3B;  // ';'
  localparam logic [ByteW-1:0] ChEquals    = 8'h3D;  // '='

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    PS_NAME  = 2'd0,
    PS_EQ    = 2'd1,
    PS_VALUE = 2'd2
  } pair_t;

  typedef enum logic [2:0] {
    ROLE_DATA      = 3'd0,
    ROLE_NAME      = 3'd1,
    ROLE_VALUE     = 3'd2,
    ROLE_END_NOVAL = 3'd3,
    ROLE_END_VAL   = 3'd4,
    ROLE_MSG_END   = 3'd5,
    ROLE_EXIT      = 3'd6,
    ROLE_ERROR     = 3'd7
  } role_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_TYPE   = 3'd1,
    ERR_HEX    = 3'd2,
    ERR_NOVAL  = 3'd3,
    ERR_NOSEMI = 3'd4,
    ERR_EOF    = 3'd5
  } err_t;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             end_of_stream;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    role_t            out_role;
    err_t             error_code;
    logic             chunk_end;
  } result_t;

  // Returns {valid, nibble} for one ASCII hex digit of either case.
  function automatic logic [4:0] hex_decode(input logic [ByteW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cfr_in_reg.sv =====
// Input register stage of the chunk frame receiver.
// Captures one received item per transfer and holds it until the parser takes it.
// Depends on cfr_pkg.
`default_nettype none

module cfr_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_valid,
  output logic               s_ready,
  input  wire cfr_pkg::item_t s_item,
  output logic               item_valid,
  output cfr_pkg::item_t     item,
  input  wire logic          item_take
);
  import cfr_pkg::*;

  assign s_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item <= s_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cfr_parse.sv =====
// Frame parser of the chunk frame receiver: header, payload and pair state.
// Updates the state for one item per cycle while step is high and forms at most one result.
// Depends on cfr_pkg.
`default_nettype none

module cfr_parse #(
  parameter int LENGTH_DIGITS = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire cfr_pkg::item_t item,
  output logic               res_valid,
  output cfr_pkg::result_t   res
);
  import cfr_pkg::*;

  localparam int LenW = 4 * LENGTH_DIGITS;
  localparam int HcW  = $clog2(LENGTH_DIGITS + 1);

  phase_t          phase, phase_next;
  pair_t           pair_state, pair_state_next;
  logic [HcW-1:0]  header_count, header_count_next;
  logic [LenW-1:0] length_accum, length_accum_next;
  logic [LenW-1:0] bytes_left, bytes_left_next;
  logic            chunk_is_extension, chunk_is_extension_next;

  logic [4:0]      hex;
  logic            last;

  assign hex  = hex_decode(item.rx_byte);
  assign last = (bytes_left == LenW'(1));

  always_comb begin
    phase_next              = phase;
    pair_state_next         = pair_state;
    header_count_next       = header_count;
    length_accum_next       = length_accum;
    bytes_left_next         = bytes_left;
    chunk_is_extension_next = chunk_is_extension;
    res_valid               = 1'b0;
    res                     = '{out_byte: '0, out_role: ROLE_DATA, error_code: ERR_NONE,
                                chunk_end: 1'b0};
    if (step) begin
      unique case (phase)
        PH_ERROR: begin
        end
        PH_PAYLOAD: begin
          if (item.end_of_stream) begin
            phase_next     = PH_ERROR;
            res_valid      = 1'b1;
            res.out_role   = ROLE_ERROR;
            res.error_code = ERR_EOF;
          end else begin
            bytes_left_next = bytes_left - LenW'(1);
            if (last) begin
              phase_next = PH_HEADER;
            end
            if (!chunk_is_extension) begin
              res_valid     = 1'b1;
              res.out_byte  = item.rx_byte;
              res.out_role  = ROLE_DATA;
              res.chunk_end = last;
            end else if (item.rx_byte == ChSemi) begin
              pair_state_next = PS_NAME;
              res_valid       = 1'b1;
              res.chunk_end   = last;
              if (pair_state == PS_EQ) begin
                phase_next     = PH_ERROR;
                res.out_role   = ROLE_ERROR;
                res.error_code = ERR_NOVAL;
              end else if (pair_state == PS_VALUE) begin
                res.out_role = ROLE_END_VAL;
              end else begin
                res.out_role = ROLE_END_NOVAL;
              end
            end else if (last) begin
              phase_next     = PH_ERROR;
              res_valid      = 1'b1;
              res.out_role   = ROLE_ERROR;
              res.error_code = ERR_NOSEMI;
              res.chunk_end  = 1'b1;
            end else if (pair_state == PS_NAME) begin
              if (item.rx_byte == ChEquals) begin
                pair_state_next = PS_EQ;
              end else begin
                res_valid    = 1'b1;
                res.out_byte = item.rx_byte;
                res.out_role = ROLE_NAME;
              end
            end else begin
              pair_state_next = PS_VALUE;
              res_valid       = 1'b1;
              res.out_byte    = item.rx_byte;
              res.out_role    = ROLE_VALUE;
            end
          end
        end
        default: begin
          if (item.end_of_stream) begin
            header_count_next = '0;
            length_accum_next = '0;
            res_valid         = 1'b1;
            res.out_role      = ROLE_EXIT;
          end else if (header_count < HcW'(LENGTH_DIGITS)) begin
            if (hex[4]) begin
              length_accum_next = LenW'({length_accum, hex[3:0]});
              header_count_next = header_count + HcW'(1);
            end else begin
              phase_next     = PH_ERROR;
              res_valid      = 1'b1;
              res.out_role   = ROLE_ERROR;
              res.error_code = ERR_HEX;
            end
          end else begin
            header_count_next = '0;
            bytes_left_next   = length_accum;
            length_accum_next = '0;
            if (item.rx_byte == ChType_Ext) begin
              if (length_accum == '0) begin
                phase_next     = PH_ERROR;
                res_valid      = 1'b1;
                res.out_role   = ROLE_ERROR;
                res.error_code = ERR_NOSEMI;
              end else begin
                chunk_is_extension_next = 1'b1;
                pair_state_next         = PS_NAME;
                phase_next              = PH_PAYLOAD;
              end
            end else if (item.rx_byte == ChType_Data) begin
              chunk_is_extension_next = 1'b0;
              if (length_accum == '0) begin
                res_valid    = 1'b1;
                res.out_role = ROLE_MSG_END;
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end else begin
              phase_next     = PH_ERROR;
              res_valid      = 1'b1;
              res.out_role   = ROLE_ERROR;
              res.error_code = ERR_TYPE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HEADER;
      pair_state         <= PS_NAME;
      header_count       <= '0;
      length_accum       <= '0;
      bytes_left         <= '0;
      chunk_is_extension <= 1'b0;
    end else begin
      phase              <= phase_next;
      pair_state         <= pair_state_next;
      header_count       <= header_count_next;
      length_accum       <= length_accum_next;
      bytes_left         <= bytes_left_next;
      chunk_is_extension <= chunk_is_extension_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.out_role != ROLE_ERROR |-> res.error_code == ERR_NONE)
    else $error("Error code set on a result that is not an error.");

  assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |=> phase == PH_ERROR)
    else $error("Error state left without reset.");

  assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |-> !res_valid)
    else $error("Result produced after an error.");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.chunk_end |-> phase == PH_PAYLOAD && last)
    else $error("Chunk end flagged outside the last payload byte.");

endmodule

`default_nettype wire

// ===== rtl/cfr_out_reg.sv =====
// Output register with skid entry for the chunk frame receiver.
// Registers each result and decouples the downstream ready from the parser.
// Depends on cfr_pkg.
`default_nettype none

module cfr_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          res_valid,
  input  wire cfr_pkg::result_t res,
  output logic               res_ready,
  output logic               m_valid,
  input  wire logic          m_ready,
  output cfr_pkg::result_t   m_res
);
  import cfr_pkg::*;

  logic    skid_valid;
  result_t skid;
  logic    push;
  logic    to_skid;

  assign res_ready = !skid_valid;
  assign push      = res_valid && res_ready;
  assign to_skid   = push && m_valid && !m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (to_skid) begin
        skid_valid <= 1'b1;
      end else begin
        m_valid <= 1'b1;
      end
    end else if (m_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (to_skid) begin
        skid <= res;
      end else begin
        m_res <= res;
      end
    end else if (m_ready && skid_valid) begin
      m_res <= skid;
    end
  end

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> m_valid)
    else $error("Skid entry holds a result while the output register is empty.");

endmodule

`default_nettype wire

// ===== rtl/chunk_frame_receiver_core.sv =====
// Top level of the chunk frame receiver.
// Instantiates the input register, the frame parser and the output register.
// Depends on cfr_pkg, cfr_in_reg, cfr_parse and cfr_out_reg.

// The receiver takes one byte per cycle while input ready is high and gives at most one
// result for it. Each byte is held in the input register, where the parser updates its
// state, and each result is held in the output register. A two-entry output stage lets
// the input accept a new byte every cycle while a finished result waits for the downstream
// side; input ready drops only when both output entries are full. The header holds
// LENGTH_DIGITS hex digits. After an error the block drops all input until reset.
`default_nettype none

module chunk_frame_receiver_core #(
  parameter int LENGTH_DIGITS = 7
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // rx_byte
  input  wire logic [0:0] s_axis_tuser,   // end_of_stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_byte
  output logic [5:0]      m_axis_tuser,   // out_role, error_code
  output logic            m_axis_tlast    // chunk_end
);
  import cfr_pkg::*;

  item_t   s_item;
  item_t   item;
  logic    item_valid;
  logic    res_ready;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t m_res;

  assign s_item = '{rx_byte: s_axis_tdata, end_of_stream: s_axis_tuser[0]};
  assign step   = item_valid && res_ready;

  cfr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (res_ready)
  );

  cfr_parse #(
    .LENGTH_DIGITS (LENGTH_DIGITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  cfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_res     (m_res)
  );

  assign m_axis_tdata = m_res.out_byte;
  assign m_axis_tuser = {m_res.error_code, m_res.out_role};
  assign m_axis_tlast = m_res.chunk_end;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for chunk_frame_receiver_core.
// Sends framed byte streams over the input stream, predicts each result and checks the output.
// Depends on cfr_pkg and the receiver RTL.
`default_nettype none

module testbench;
  import cfr_pkg::*;

  localparam int LEN_DIGITS  = 7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  typedef enum int {
    BREAK_HEX,
    BREAK_TYPE,
    BREAK_EMPTY_EXT,
    BREAK_EQ_SEMI,
    BREAK_NO_SEMI,
    BREAK_EOF
  } fault_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic [0:0] s_axis_tuser = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [5:0] m_axis_tuser;
  logic       m_axis_tlast;

  bit      idle_en = 1'b1;
  bit      hold_off_req = 1'b0;
  int      sent_items = 0;
  int      mismatches = 0;
  int      cycle_count = 0;
  result_t pending_results[$];

  phase_t                  fr_phase = PH_HEADER;
  int                      digits_seen = 0;
  logic [4*LEN_DIGITS-1:0] len_acc = '0;
  logic [4*LEN_DIGITS-1:0] remaining = '0;
  bit                      in_ext = 1'b0;
  pair_t                   pair_pos = PS_NAME;

  chunk_frame_receiver_core #(
    .LENGTH_DIGITS(LEN_DIGITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return 8'h30 + nib;
    return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  function automatic result_t make_result(input logic [7:0] b, input role_t role,
                                          input err_t err, input logic last);
    result_t r;
    r.out_byte   = b;
    r.out_role   = role;
    r.error_code = err;
    r.chunk_end  = last;
    return r;
  endfunction

  // Advances the predicted parser state by one byte; returns 1 when a result is due.
  function automatic bit deframe_byte(input logic [7:0] b, input logic eos,
                                      output result_t r);
    logic [4:0] nib;
    logic       last;
    pair_t      prev;
    r = make_result(8'h00, ROLE_DATA, ERR_NONE, 1'b0);
    if (fr_phase == PH_ERROR) return 1'b0;
    if (fr_phase == PH_PAYLOAD) begin
      if (eos) begin
        fr_phase = PH_ERROR;
        r = make_result(8'h00, ROLE_ERROR, ERR_EOF, 1'b0);
        return 1'b1;
      end
      last = (remaining == 1);
      remaining = remaining - 1'b1;
      if (last) fr_phase = PH_HEADER;
      if (!in_ext) begin
        r = make_result(b, ROLE_DATA, ERR_NONE, last);
        return 1'b1;
      end
      if (b == ChSemi) begin
        prev = pair_pos;
        pair_pos = PS_NAME;
        if (prev == PS_EQ) begin
          fr_phase = PH_ERROR;
          r = make_result(8'h00, ROLE_ERROR, ERR_NOVAL, last);
        end else begin
          r = make_result(8'h00, prev == PS_VALUE ? ROLE_END_VAL : ROLE_END_NOVAL,
                          ERR_NONE, last);
        end
        return 1'b1;
      end
      if (last) begin
        fr_phase = PH_ERROR;
        r = make_result(8'h00, ROLE_ERROR, ERR_NOSEMI, 1'b1);
        return 1'b1;
      end
      if (pair_pos == PS_NAME) begin
        if (b == ChEquals) begin
          pair_pos = PS_EQ;
          return 1'b0;
        end
        r = make_result(b, ROLE_NAME, ERR_NONE, 1'b0);
        return 1'b1;
      end
      pair_pos = PS_VALUE;
      r = make_result(b, ROLE_VALUE, ERR_NONE, 1'b0);
      return 1'b1;
    end
    if (eos) begin
      digits_seen = 0;
      len_acc = '0;
      r = make_result(8'h00, ROLE_EXIT, ERR_NONE, 1'b0);
      return 1'b1;
    end
    if (digits_seen < LEN_DIGITS) begin
      nib = digit_value(b);
      if (!nib[4]) begin
        fr_phase = PH_ERROR;
        r = make_result(8'h00, ROLE_ERROR, ERR_HEX, 1'b0);
        return 1'b1;
      end
      len_acc = (len_acc << 4) | nib[3:0];
      digits_seen++;
      return 1'b0;
    end
    digits_seen = 0;
    remaining = len_acc;
    len_acc = '0;
    if (b == ChType_Ext) begin
      if (remaining == 0) begin
        fr_phase = PH_ERROR;
        r = make_result(8'h00, ROLE_ERROR, ERR_NOSEMI, 1'b0);
        return 1'b1;
      end
      in_ext = 1'b1;
      pair_pos = PS_NAME;
      fr_phase = PH_PAYLOAD;
      return 1'b0;
    end
    if (b == ChType_Data) begin
      in_ext = 1'b0;
      if (remaining == 0) begin
        r = make_result(8'h00, ROLE_MSG_END, ERR_NONE, 1'b0);
        return 1'b1;
      end
      fr_phase = PH_PAYLOAD;
      return 1'b0;
    end
    fr_phase = PH_ERROR;
    r = make_result(8'h00, ROLE_ERROR, ERR_TYPE, 1'b0);
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    result_t r;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eos;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (deframe_byte(b, eos, r)) pending_results.push_back(r);
    sent_items++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_header(input int unsigned len, input logic [7:0] kind);
    for (int i = LEN_DIGITS - 1; i >= 0; i--) begin
      send_byte(hex_char(4'((len >> (4 * i)) & 4'hF), 1'($urandom_range(0, 1))), 1'b0);
    end
    send_byte(kind, 1'b0);
  endtask

  task automatic send_chunk(input logic [7:0] kind, input logic [7:0] body[$]);
    send_header(body.size(), kind);
    foreach (body[i]) send_byte(body[i], 1'b0);
  endtask

  task automatic send_data_chunk(input int unsigned len);
    logic [7:0] body[$];
    repeat (len) body.push_back(8'($urandom_range(0, 255)));
    send_chunk(ChType_Data, body);
  endtask

  task automatic send_ext_chunk();
    logic [7:0] body[$];
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(0, 4)) begin
        do b = 8'($urandom_range(0, 255)); while (b == ChSemi || b == ChEquals);
        body.push_back(b);
      end
      if ($urandom_range(0, 1)) begin
        body.push_back(ChEquals);
        repeat ($urandom_range(1, 4)) begin
          do b = ($urandom_range(0, 3) == 0) ? ChEquals : 8'($urandom_range(0, 255));
          while (b == ChSemi);
          body.push_back(b);
        end
      end
      body.push_back(ChSemi);
    end
    send_chunk(ChType_Ext, body);
  endtask

  task automatic send_broken_header();
    repeat ($urandom_range(0, LEN_DIGITS)) begin
      send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_data_passthrough();
    send_chunk(ChType_Data, {8'h00, 8'hFF});
  endtask

  task automatic test_extension_pairs();
    send_chunk(ChType_Ext, {8'h6E, ChSemi, ChEquals, 8'h62, ChEquals, ChSemi});
  endtask

  task automatic test_message_end_and_exit();
    send_header(0, ChType_Data);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_output_backpressure();
    hold_off_req = 1'b1;
    send_data_chunk(48);
    send_header(0, ChType_Data);
  endtask

  task automatic test_drain_pause();
    send_ext_chunk();
    wait_drained();
    send_data_chunk(5);
    send_header(0, ChType_Data);
  endtask

  task automatic test_random_messages(input int target);
    while (sent_items < target) begin
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 9) == 0) send_broken_header();
        if ($urandom_range(0, 2) == 0) begin
          send_ext_chunk();
        end else begin
          send_data_chunk(($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 16));
        end
      end
      send_header(0, ChType_Data);
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic test_sticky_error();
    fault_t     fault;
    logic [7:0] b;
    fault = fault_t'($urandom_range(0, 5));
    case (fault)
      BREAK_HEX: begin
        repeat ($urandom_range(0, LEN_DIGITS - 1)) send_byte(8'h30, 1'b0);
        do b = 8'($urandom_range(0, 255)); while (digit_value(b) != 5'd0);
        send_byte(b, 1'b0);
      end
      BREAK_TYPE: begin
        do b = 8'($urandom_range(0, 255)); while (b == ChType_Ext || b == ChType_Data);
        send_header(1, b);
      end
      BREAK_EMPTY_EXT: send_header(0, ChType_Ext);
      BREAK_EQ_SEMI:   send_chunk(ChType_Ext, {8'h61, ChEquals, ChSemi});
      BREAK_NO_SEMI:   send_chunk(ChType_Ext, {8'h61, ChEquals, 8'h62});
      BREAK_EOF: begin
        send_header(4, ChType_Data);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: ;
    endcase
    repeat (12) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int stall;
    forever begin
      @(posedge clk);
      stall = 0;
      if (hold_off_req) begin
        stall = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 7);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result expected none actual byte %0h tuser %0h last %0b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_byte", want.out_byte, m_axis_tdata);
        check_field("out_role", 8'(want.out_role), 8'(m_axis_tuser[2:0]));
        check_field("error_code", 8'(want.error_code), 8'(m_axis_tuser[5:3]));
        check_field("chunk_end", 8'(want.chunk_end), 8'(m_axis_tlast));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_data_passthrough();
    test_extension_pairs();
    test_message_end_and_exit();
    test_output_backpressure();
    test_drain_pause();
    test_random_messages(950);
    idle_en = 1'b0;
    test_random_messages(1100);
    test_sticky_error();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/cfr_pkg.sv
rtl/cfr_in_reg.sv
rtl/cfr_parse.sv
rtl/cfr_out_reg.sv
rtl/chunk_frame_receiver_core.sv
tb/testbench.sv
